### rtl/sawarq_pkg.sv
// Shared types, codes and helpers of the stop-and-wait ARQ endpoint.
`timescale 1ns / 1ps
package sawarq_pkg;

    // Input item kinds (carried on s_tuser)
    localparam logic [1:0] MODE_SEND = 2'd0;
    localparam logic [1:0] MODE_RX   = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_TRY_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_DATA_TYPE   = 2'd2;
    localparam logic [1:0] CFG_ACK_TYPE    = 2'd3;

    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd5000;
    localparam logic [3:0]  TRY_LIMIT_RST   = 4'd3;
    localparam logic [7:0]  DATA_TYPE_RST   = 8'd0;
    localparam logic [7:0]  ACK_TYPE_RST    = 8'd1;

    // Output buffer: four result slots
    localparam int unsigned OBUF_AW = 2;

    typedef enum logic [2:0] {
        ACT_SEND_DATA  = 3'd0,
        ACT_SEND_ACK   = 3'd1,
        ACT_DELIVER    = 3'd2,
        ACT_SEND_FAIL  = 3'd3,
        ACT_QUEUE_FULL = 3'd4
    } action_t;

    typedef struct packed {
        logic [15:0] port;
        logic [31:0] addr;
        logic [15:0] handle;
    } entry_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  out_type;
        logic [7:0]  out_seq;
        entry_t      peer;
        logic        last;
    } result_t;

    // Up to two results written per processed transaction
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } res_wr_t;

    function automatic result_t mk_result(action_t a, logic [7:0] t, logic [7:0] s,
                                          entry_t e);
        result_t r;
        r.action   = a;
        r.out_type = t;
        r.out_seq  = s;
        r.peer     = e;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

### rtl/sawarq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sawarq_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/sawarq_out_buf.sv
// Four-slot result buffer: takes up to two results a cycle, hands out one while the sink is ready.
`timescale 1ns / 1ps
module sawarq_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  sawarq_pkg::res_wr_t wr,
    output logic                room,
    output logic                m_tvalid,
    input  logic                m_tready,
    output sawarq_pkg::result_t m_res
);
    localparam int unsigned AW = sawarq_pkg::OBUF_AW;

    sawarq_pkg::result_t mem_reg [2**AW];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          pop;

    // room for two more results
    assign room     = cnt_reg <= (AW+1)'(2**AW - 2);
    assign m_tvalid = cnt_reg != '0;
    assign m_res    = mem_reg[rd_ptr_reg];
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(wr.cnt);
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (AW+1)'(wr.cnt) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= wr.r0;
        end
        if (wr.cnt == 2'd2) begin
            mem_reg[wr_ptr_reg + AW'(1)] <= wr.r1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.cnt != 2'd0 |-> room)
        else $error("result buffer written without room");
`endif

endmodule

### rtl/sawarq_core.sv
// Input register, ARQ state, send queue control and per-transaction decision.
`timescale 1ns / 1ps
module sawarq_core #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input transactions, fields already unpacked
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_mode,
    input  logic [7:0]          s_frame_type,
    input  logic [7:0]          s_frame_seq,
    input  sawarq_pkg::entry_t  s_peer,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    // results
    input  logic                room,
    output sawarq_pkg::res_wr_t res_wr
);
    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SW = AW + 1;
    localparam int unsigned EW = $bits(sawarq_pkg::entry_t);

    // configuration
    logic [15:0] ack_timeout_reg;
    logic [3:0]  try_limit_reg;
    logic [7:0]  data_type_reg;
    logic [7:0]  ack_type_reg;

    // input register
    logic               in_valid_reg, in_valid_next;
    logic [1:0]         in_mode_reg;
    logic [7:0]         in_type_reg;
    logic [7:0]         in_seq_reg;
    sawarq_pkg::entry_t in_peer_reg;

    // protocol state
    logic               waiting_reg, waiting_next;
    logic [7:0]         seq_reg, seq_next;
    logic [3:0]         attempt_reg, attempt_next;
    logic [15:0]        ticks_reg, ticks_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    sawarq_pkg::entry_t head_entry_reg, head_entry_next;

    // queue storage and the entry behind the head
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [EW-1:0]      rd_data;
    logic               fwd_reg;
    sawarq_pkg::entry_t fwd_data_reg;
    sawarq_pkg::entry_t next_entry;
    logic [SW-1:0]      tail_sum;

    logic               fire;
    logic               do_fail;
    logic               do_pop;
    logic [3:0]         att_inc;
    logic [15:0]        ticks_inc;
    logic [1:0]         rcnt;
    sawarq_pkg::result_t res0, res1, send_next;

    function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign wr_addr  = (tail_sum >= SW'(QUEUE_DEPTH)) ?
                      AW'(tail_sum - SW'(QUEUE_DEPTH)) : tail_sum[AW-1:0];
    // read data lines up with the state written at the same edge
    assign rd_addr  = ptr_inc(head_next);
    assign next_entry = fwd_reg ? fwd_data_reg : sawarq_pkg::entry_t'(rd_data);

    assign ticks_inc = (ticks_reg != 16'hFFFF) ? ticks_reg + 16'd1 : ticks_reg;
    assign att_inc   = attempt_reg + 4'd1;

    always_comb begin
        in_valid_next   = in_valid_reg;
        waiting_next    = waiting_reg;
        seq_next        = seq_reg;
        attempt_next    = attempt_reg;
        ticks_next      = ticks_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        head_entry_next = head_entry_reg;
        wr_en           = 1'b0;
        do_fail         = 1'b0;
        do_pop          = 1'b0;
        rcnt            = 2'd0;
        res0            = '0;
        res1            = '0;
        send_next = sawarq_pkg::mk_result(sawarq_pkg::ACT_SEND_DATA, data_type_reg,
                                          seq_reg + 8'd1, next_entry);

        if (fire) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end

        if (fire) begin
            unique case (in_mode_reg)
                sawarq_pkg::MODE_SEND: begin
                    if (count_reg >= CW'(QUEUE_DEPTH)) begin
                        res0 = sawarq_pkg::mk_result(sawarq_pkg::ACT_QUEUE_FULL, 8'd0, 8'd0,
                                                     in_peer_reg);
                        rcnt = 2'd1;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (count_reg == '0) begin
                            head_entry_next = in_peer_reg;
                        end
                        // idle means empty, so the new entry is the head
                        if (!waiting_reg) begin
                            seq_next     = seq_reg + 8'd1;
                            res0 = sawarq_pkg::mk_result(sawarq_pkg::ACT_SEND_DATA,
                                                         data_type_reg, seq_reg + 8'd1,
                                                         in_peer_reg);
                            rcnt         = 2'd1;
                            waiting_next = 1'b1;
                            ticks_next   = '0;
                        end
                    end
                end
                sawarq_pkg::MODE_RX: begin
                    if (in_type_reg == data_type_reg) begin
                        res0 = sawarq_pkg::mk_result(sawarq_pkg::ACT_SEND_ACK, ack_type_reg,
                                                     in_seq_reg,
                                                     '{port: in_peer_reg.port,
                                                       addr: in_peer_reg.addr,
                                                       handle: 16'd0});
                        res1 = sawarq_pkg::mk_result(sawarq_pkg::ACT_DELIVER, in_type_reg,
                                                     in_seq_reg, in_peer_reg);
                        rcnt = 2'd2;
                    end else if (in_type_reg == ack_type_reg && waiting_reg) begin
                        if (in_seq_reg == seq_reg) begin
                            do_pop = 1'b1;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                end
                sawarq_pkg::MODE_TICK: begin
                    if (waiting_reg) begin
                        ticks_next = ticks_inc;
                        if (ticks_inc >= ack_timeout_reg) begin
                            do_fail = 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            if (do_fail) begin
                if (att_inc < try_limit_reg) begin
                    res0 = sawarq_pkg::mk_result(sawarq_pkg::ACT_SEND_DATA, data_type_reg,
                                                 seq_reg, head_entry_reg);
                    rcnt         = 2'd1;
                    attempt_next = att_inc;
                    ticks_next   = '0;
                end else begin
                    res0 = sawarq_pkg::mk_result(sawarq_pkg::ACT_SEND_FAIL, 8'd0, seq_reg,
                                                 head_entry_reg);
                    rcnt   = 2'd1;
                    do_pop = 1'b1;
                end
            end

            if (do_pop) begin
                head_next       = ptr_inc(head_reg);
                count_next      = count_reg - CW'(1);
                head_entry_next = next_entry;
                waiting_next    = 1'b0;
                ticks_next      = '0;
                attempt_next    = '0;
                // back to idle with frames left: send the next one at once
                if (count_reg > CW'(1)) begin
                    seq_next     = seq_reg + 8'd1;
                    waiting_next = 1'b1;
                    if (rcnt == 2'd0) begin
                        res0 = send_next;
                    end else begin
                        res1 = send_next;
                    end
                    rcnt = rcnt + 2'd1;
                end
            end
        end

        if (rcnt == 2'd1) begin
            res0.last = 1'b1;
        end
        if (rcnt == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    assign res_wr.cnt = rcnt;
    assign res_wr.r0  = res0;
    assign res_wr.r1  = res1;

    sawarq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_peer_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg <= sawarq_pkg::ACK_TIMEOUT_RST;
            try_limit_reg   <= sawarq_pkg::TRY_LIMIT_RST;
            data_type_reg   <= sawarq_pkg::DATA_TYPE_RST;
            ack_type_reg    <= sawarq_pkg::ACK_TYPE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sawarq_pkg::CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_wdata;
                sawarq_pkg::CFG_TRY_LIMIT:   try_limit_reg   <= cfg_wdata[3:0];
                sawarq_pkg::CFG_DATA_TYPE:   data_type_reg   <= cfg_wdata[7:0];
                sawarq_pkg::CFG_ACK_TYPE:    ack_type_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            waiting_reg  <= 1'b0;
            seq_reg      <= '0;
            attempt_reg  <= '0;
            ticks_reg    <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            fwd_reg      <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            waiting_reg  <= waiting_next;
            seq_reg      <= seq_next;
            attempt_reg  <= attempt_next;
            ticks_reg    <= ticks_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            fwd_reg      <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_mode;
            in_type_reg <= s_frame_type;
            in_seq_reg  <= s_frame_seq;
            in_peer_reg <= s_peer;
        end
        head_entry_reg <= head_entry_next;
        fwd_data_reg   <= in_peer_reg;
    end

`ifndef SYNTHESIS
    a_wait_has_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        waiting_reg |-> count_reg != '0)
        else $error("waiting for an ack with an empty queue");
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !waiting_reg |-> attempt_reg == '0 && ticks_reg == '0)
        else $error("idle with retry state left over");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_res_on_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        res_wr.cnt != 2'd0 |-> fire)
        else $error("result produced without a transaction");
`endif

endmodule

### rtl/stop_and_wait_arq_endpoint.sv
// Top level of the stop-and-wait ARQ endpoint.
`timescale 1ns / 1ps
// Usage:
//   s_ channel: one transaction per event. s_tuser is the kind: send request,
//   received frame header, or timer tick. s_tdata carries the frame header bytes,
//   the peer port/address and the payload handle.
//   m_ channel: actions (send data, send ack, deliver, send failed, queue full)
//   with m_tlast on the last action caused by one input transaction.
//   cfg_ port: write-only register file (timeout, try limit, DATA/ACK type codes);
//   the user must write it only while the block is idle; the block does not enforce this.
// Path: the first action of an accepted transaction passes through the input register
//   and then the result buffer before it is valid on m_.
// Throughput: one transaction per cycle while each causes at most one action and
//   the sink keeps up; transactions that cause two actions are held back by the
//   one-action-per-cycle m_ channel, which feeds from a four-slot result buffer.
// Reset: queue empty, idle, sequence number 0, registers at defaults.
// Sink stall: results collect in the result buffer; once fewer than two slots
//   are free, s_tready drops after the input register fills. Nothing is lost.
module stop_and_wait_arq_endpoint #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // frame_type, frame_seq, peer_port, peer_addr, payload_handle
    input  logic [1:0]  s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // out_type, out_seq, out_port, out_addr, out_handle
    output logic [2:0]  m_tuser,  // action
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    sawarq_pkg::entry_t  s_peer;
    sawarq_pkg::res_wr_t res_wr;
    sawarq_pkg::result_t m_res;
    logic                room;

    assign s_peer.port   = s_tdata[31:16];
    assign s_peer.addr   = s_tdata[63:32];
    assign s_peer.handle = s_tdata[79:64];

    sawarq_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_mode       (s_tuser),
        .s_frame_type (s_tdata[7:0]),
        .s_frame_seq  (s_tdata[15:8]),
        .s_peer       (s_peer),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .room         (room),
        .res_wr       (res_wr)
    );

    sawarq_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (res_wr),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {m_res.peer.handle, m_res.peer.addr, m_res.peer.port,
                      m_res.out_seq, m_res.out_type};
    assign m_tuser = m_res.action;
    assign m_tlast = m_res.last;

endmodule

### verif/testbench.sv
// Self-checking testbench for the stop-and-wait ARQ endpoint.
`timescale 1ns / 1ps
module testbench;

    localparam int unsigned DEPTH = 8;
    localparam logic [1:0] MODE_NONE = 2'd3;  // unused kind, must be ignored

    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  ftype;
        logic [7:0]  fseq;
        logic [15:0] port;
        logic [31:0] addr;
        logic [15:0] handle;
    } arq_event_t;

    // Tracks the endpoint state and holds the actions it must emit, oldest first.
    class arq_action_tracker;
        logic [15:0] ack_timeout;
        logic [3:0]  try_limit;
        logic [7:0]  data_code;
        logic [7:0]  ack_code;
        bit          waiting;
        logic [7:0]  send_seq;
        logic [3:0]  attempts;
        logic [15:0] wait_ticks;
        sawarq_pkg::entry_t  store [DEPTH];
        logic [2:0]  head;
        logic [3:0]  count;
        sawarq_pkg::result_t batch [$];
        sawarq_pkg::result_t expected_actions [$];
        int          mismatches;

        function new();
            ack_timeout = sawarq_pkg::ACK_TIMEOUT_RST;
            try_limit   = sawarq_pkg::TRY_LIMIT_RST;
            data_code   = sawarq_pkg::DATA_TYPE_RST;
            ack_code    = sawarq_pkg::ACK_TYPE_RST;
            waiting     = 1'b0;
            send_seq    = '0;
            attempts    = '0;
            wait_ticks  = '0;
            head        = '0;
            count       = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                sawarq_pkg::CFG_ACK_TIMEOUT: ack_timeout = val;
                sawarq_pkg::CFG_TRY_LIMIT:   try_limit   = val[3:0];
                sawarq_pkg::CFG_DATA_TYPE:   data_code   = val[7:0];
                sawarq_pkg::CFG_ACK_TYPE:    ack_code    = val[7:0];
                default: ;
            endcase
        endfunction

        function void emit(sawarq_pkg::action_t act, logic [7:0] typ, logic [7:0] seq,
                           sawarq_pkg::entry_t e);
            sawarq_pkg::result_t r;
            r.action   = act;
            r.out_type = typ;
            r.out_seq  = seq;
            r.peer     = e;
            r.last     = 1'b0;
            batch = {batch, r};
        endfunction

        function void send_head(bit fresh);
            if (fresh)
                send_seq = send_seq + 8'd1;
            emit(sawarq_pkg::ACT_SEND_DATA, data_code, send_seq, store[head]);
            waiting    = 1'b1;
            wait_ticks = '0;
        endfunction

        function void pop_head();
            if (count > 0) begin
                head  = head + 3'd1;
                count = count - 4'd1;
            end
        endfunction

        function void go_idle();
            waiting    = 1'b0;
            wait_ticks = '0;
            attempts   = '0;
            if (count > 0)
                send_head(1'b1);
        endfunction

        // Timeout or wrong ACK: retry the head, or give up on it.
        function void missed_ack();
            attempts = attempts + 4'd1;
            if (attempts < try_limit) begin
                send_head(1'b0);
            end else begin
                emit(sawarq_pkg::ACT_SEND_FAIL, 8'd0, send_seq, store[head]);
                pop_head();
                go_idle();
            end
        endfunction

        function void note_event(arq_event_t ev);
            sawarq_pkg::entry_t e;
            sawarq_pkg::entry_t ack_peer;
            logic [2:0]         slot;
            e        = '{port: ev.port, addr: ev.addr, handle: ev.handle};
            ack_peer = '{port: ev.port, addr: ev.addr, handle: 16'd0};
            case (ev.mode)
                sawarq_pkg::MODE_SEND: begin
                    if (count >= DEPTH) begin
                        emit(sawarq_pkg::ACT_QUEUE_FULL, 8'd0, 8'd0, e);
                    end else begin
                        slot        = head + count[2:0];
                        store[slot] = e;
                        count       = count + 4'd1;
                        if (!waiting)
                            send_head(1'b1);
                    end
                end
                sawarq_pkg::MODE_RX: begin
                    if (ev.ftype == data_code) begin
                        emit(sawarq_pkg::ACT_SEND_ACK, ack_code, ev.fseq, ack_peer);
                        emit(sawarq_pkg::ACT_DELIVER, ev.ftype, ev.fseq, e);
                    end else if (ev.ftype == ack_code && waiting) begin
                        if (ev.fseq == send_seq) begin
                            pop_head();
                            go_idle();
                        end else begin
                            missed_ack();
                        end
                    end
                end
                sawarq_pkg::MODE_TICK: begin
                    if (waiting) begin
                        if (wait_ticks != 16'hFFFF)
                            wait_ticks = wait_ticks + 16'd1;
                        if (wait_ticks >= ack_timeout)
                            missed_ack();
                    end
                end
                default: ;
            endcase
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            expected_actions = {expected_actions, batch};
            batch.delete();
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_action(sawarq_pkg::result_t got);
            sawarq_pkg::result_t want;
            if (expected_actions.size() == 0) begin
                $error("action %0d with nothing pending", got.action);
                mismatches++;
                return;
            end
            want = expected_actions[0];
            expected_actions.delete(0);
            compare("action", 32'(want.action), 32'(got.action));
            compare("out_type", 32'(want.out_type), 32'(got.out_type));
            compare("out_seq", 32'(want.out_seq), 32'(got.out_seq));
            compare("out_port", 32'(want.peer.port), 32'(got.peer.port));
            compare("out_addr", want.peer.addr, got.peer.addr);
            compare("out_handle", 32'(want.peer.handle), 32'(got.peer.handle));
            compare("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // frame_type, frame_seq, peer_port, peer_addr, payload_handle
    logic [1:0]  s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // out_type, out_seq, out_port, out_addr, out_handle
    logic [2:0]  m_tuser;   // action
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    arq_action_tracker sb = new();
    int send_calm = 0;
    int sink_calm = 0;

    stop_and_wait_arq_endpoint #(.QUEUE_DEPTH(DEPTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("stop_and_wait_arq_endpoint test failed");
        $finish;
    end

    // Idle cycles before the next transaction; occasional stretches run back to back.
    function automatic int idle_cycles(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic arq_event_t mk_ev(logic [1:0] m, logic [7:0] t, logic [7:0] s,
                                         logic [15:0] p, logic [31:0] a, logic [15:0] h);
        arq_event_t ev;
        ev.mode   = m;
        ev.ftype  = t;
        ev.fseq   = s;
        ev.port   = p;
        ev.addr   = a;
        ev.handle = h;
        return ev;
    endfunction

    // Mostly well-formed traffic steered by the tracked endpoint state.
    function automatic arq_event_t pick_event();
        arq_event_t ev;
        int r;
        ev = mk_ev(sawarq_pkg::MODE_SEND, 8'($urandom()), 8'($urandom()),
                   16'($urandom()), $urandom(), 16'($urandom()));
        r  = $urandom_range(0, 99);
        if (sb.waiting) begin
            if (r < 35) begin
                ev.mode = sawarq_pkg::MODE_RX; ev.ftype = sb.ack_code; ev.fseq = sb.send_seq;
            end else if (r < 43) begin
                ev.mode  = sawarq_pkg::MODE_RX; ev.ftype = sb.ack_code;
                ev.fseq  = sb.send_seq + 8'($urandom_range(1, 255));
            end else if (r < 68) begin
                ev.mode = sawarq_pkg::MODE_TICK;
            end else if (r < 80) begin
                ev.mode = sawarq_pkg::MODE_SEND;
            end else if (r < 90) begin
                ev.mode = sawarq_pkg::MODE_RX; ev.ftype = sb.data_code;
            end else if (r < 97) begin
                ev.mode = sawarq_pkg::MODE_RX;
            end else begin
                ev.mode = MODE_NONE;
            end
        end else begin
            if (r < 45) begin
                ev.mode = sawarq_pkg::MODE_SEND;
            end else if (r < 60) begin
                ev.mode = sawarq_pkg::MODE_RX; ev.ftype = sb.data_code;
            end else if (r < 70) begin
                ev.mode = sawarq_pkg::MODE_RX; ev.ftype = sb.ack_code;
            end else if (r < 85) begin
                ev.mode = sawarq_pkg::MODE_TICK;
            end else if (r < 97) begin
                ev.mode = sawarq_pkg::MODE_RX;
            end else begin
                ev.mode = MODE_NONE;
            end
        end
        return ev;
    endfunction

    task automatic drive_item(arq_event_t ev);
        int gap;
        gap = idle_cycles(send_calm);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.mode;
        s_tdata  <= {ev.handle, ev.addr, ev.port, ev.fseq, ev.ftype};
        do @(posedge aclk); while (!s_tready);
        sb.note_event(ev);
    endtask

    // Drop valid, wait for every pending action, then let the pipeline drain.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_actions.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic program_regs(logic [15:0] tmo, logic [3:0] tries,
                                logic [7:0] dcode, logic [7:0] acode);
        logic [15:0] vals [4];
        vals[sawarq_pkg::CFG_ACK_TIMEOUT] = tmo;
        vals[sawarq_pkg::CFG_TRY_LIMIT]   = {12'd0, tries};
        vals[sawarq_pkg::CFG_DATA_TYPE]   = {8'd0, dcode};
        vals[sawarq_pkg::CFG_ACK_TYPE]    = {8'd0, acode};
        for (int i = 0; i < 4; i++) begin
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= 2'(i);
            cfg_wdata <= vals[i];
            sb.set_reg(2'(i), vals[i]);
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sink: random stall before each accepted action.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = idle_cycles(sink_calm);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        sawarq_pkg::result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.action      = sawarq_pkg::action_t'(m_tuser);
            got.out_type    = m_tdata[7:0];
            got.out_seq     = m_tdata[15:8];
            got.peer.port   = m_tdata[31:16];
            got.peer.addr   = m_tdata[63:32];
            got.peer.handle = m_tdata[79:64];
            got.last        = m_tlast;
            sb.check_action(got);
        end
    end

    initial begin
        logic [15:0] tmo_set [7];
        logic [3:0]  try_set [7];
        logic [7:0]  dat_set [7];
        logic [7:0]  ack_set [7];
        arq_event_t  ev;
        int          done;

        tmo_set = '{16'd1, 16'd3, 16'hFFFF, 16'd2, 16'd5, 16'd4, 16'd1};
        try_set = '{4'd1, 4'd15, 4'd4, 4'd3, 4'd7, 4'd2, 4'd1};
        dat_set = '{8'h00, 8'hA5, 8'h00, 8'h10, 8'hFF, 8'h3C, 8'h00};
        ack_set = '{8'hFF, 8'h5A, 8'h01, 8'h10, 8'h00, 8'hC3, 8'h00};

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = sawarq_pkg::MODE_SEND;
        cfg_wr_en = 1'b0;
        cfg_index = sawarq_pkg::CFG_ACK_TIMEOUT;
        cfg_wdata = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, reset settings.
        drive_item(mk_ev(sawarq_pkg::MODE_SEND, 8'h00, 8'h00, 16'h0, 32'h0, 16'h0));
        drive_item(mk_ev(MODE_NONE, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
        drive_item(mk_ev(sawarq_pkg::MODE_TICK, 8'h00, 8'h00, 16'h0, 32'h0, 16'h0));
        drive_item(mk_ev(sawarq_pkg::MODE_RX, sb.ack_code, sb.send_seq + 8'd1,
                         16'h1, 32'h1, 16'h1));
        drive_item(mk_ev(sawarq_pkg::MODE_RX, sb.ack_code, sb.send_seq, 16'h2, 32'h2, 16'h2));
        drive_item(mk_ev(sawarq_pkg::MODE_TICK, 8'h00, 8'h00, 16'h0, 32'h0, 16'h0));
        // ACK with nothing outstanding
        drive_item(mk_ev(sawarq_pkg::MODE_RX, sb.ack_code, 8'h01, 16'h3, 32'h3, 16'h3));
        drive_item(mk_ev(sawarq_pkg::MODE_RX, sb.data_code, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
                         16'hFFFF));
        drive_item(mk_ev(sawarq_pkg::MODE_RX, 8'h7E, 8'h55, 16'h4, 32'h4, 16'h4));
        // fill the queue, then one more is refused
        for (int i = 0; i < DEPTH + 1; i++)
            drive_item(mk_ev(sawarq_pkg::MODE_SEND, 8'h00, 8'h00, 16'hFFFF - 16'(i),
                             32'hFFFF_FFFF - 32'(i), 16'hFFFF - 16'(i)));
        settle();

        // Zero timeout, zero try limit, equal type codes.
        program_regs(16'd0, 4'd0, 8'hFF, 8'hFF);
        drive_item(mk_ev(sawarq_pkg::MODE_TICK, 8'h00, 8'h00, 16'h0, 32'h0, 16'h0));
        drive_item(mk_ev(sawarq_pkg::MODE_RX, 8'hFF, 8'h80, 16'h8000, 32'h8000_0000,
                         16'h8000));
        drive_item(mk_ev(sawarq_pkg::MODE_RX, 8'hFF, sb.send_seq, 16'h5, 32'h5, 16'h5));
        drive_item(mk_ev(sawarq_pkg::MODE_TICK, 8'h00, 8'h00, 16'h0, 32'h0, 16'h0));
        settle();

        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6)
                program_regs(16'($urandom_range(1, 6)), 4'($urandom_range(1, 15)),
                             8'($urandom()), 8'($urandom()));
            else
                program_regs(tmo_set[ph], try_set[ph], dat_set[ph], ack_set[ph]);
            done = 0;
            while (done < 195) begin
                if ($urandom_range(0, 39) == 0) begin
                    // burst of requests to push the queue to full
                    for (int i = 0; i < 10; i++) begin
                        ev      = pick_event();
                        ev.mode = sawarq_pkg::MODE_SEND;
                        drive_item(ev);
                    end
                    done += 10;
                end else begin
                    ev = pick_event();
                    drive_item(ev);
                    if (ev.mode != MODE_NONE)
                        done++;
                end
            end
            settle();
        end

        if (sb.mismatches == 0 && sb.expected_actions.size() == 0)
            $display("stop_and_wait_arq_endpoint test passed");
        else
            $display("stop_and_wait_arq_endpoint test failed");
        $finish;
    end

endmodule
